// ===== rtl/jfmd_pkg.sv =====
// Shared types and constants for the joystick frame to motor drive block.
// Holds the drive command record, register indexes and the divide-by-20 helper.
// No dependencies.
package jfmd_pkg;

	// Register indexes on the configuration port (byte address 4*index)
	localparam logic REG_BAND_LOW  = 1'b0;
	localparam logic REG_BAND_HIGH = 1'b1;

	// Reset values of the dead band
	localparam logic [15:0] BAND_LOW_RST  = 16'd1950;
	localparam logic [15:0] BAND_HIGH_RST = 16'd2150;

	// Byte position within a four-byte frame
	localparam logic [1:0] POS_H_LO = 2'd0;
	localparam logic [1:0] POS_H_HI = 2'd1;
	localparam logic [1:0] POS_V_LO = 2'd2;
	localparam logic [1:0] POS_V_HI = 2'd3;

	// x/5 == (x * 52429) >> 18 holds exactly for every x below 2^16
	localparam logic [16:0] RECIP_DIV5 = 17'd52429;
	localparam int          RECIP_SHIFT = 18;

	// One motor command pair, left_dir in the lowest bit
	typedef struct packed {
		logic [11:0] right_speed;
		logic        right_dir;
		logic [11:0] left_speed;
		logic        left_dir;
	} drive_t;

	// One assembled joystick frame
	typedef struct packed {
		logic [15:0] vert;
		logic [15:0] horiz;
	} frame_t;

	// Divide a 16-bit value by 20: drop two bits, then divide by 5 by reciprocal
	function automatic logic [11:0] div20(input logic [15:0] val);
		logic [13:0] quarter;
		logic [30:0] prod;
		quarter = val[15:2];
		prod    = {17'd0, quarter} * {14'd0, RECIP_DIV5};
		return prod[RECIP_SHIFT +: 12];
	endfunction

endpackage

// ===== rtl/jfmd_drive.sv =====
// Motor command decision for one assembled joystick frame.
// Dead-band compares, offset subtract and divide-by-20; pure combinational logic.
// Depends on jfmd_pkg.
module jfmd_drive (
	input  jfmd_pkg::frame_t    frame,
	input  logic [15:0]         band_low,
	input  logic [15:0]         band_high,
	output jfmd_pkg::drive_t    drive
);
	import jfmd_pkg::*;

	logic        h_centered;
	logic        v_centered;
	logic        h_below;
	logic        v_below;
	logic [15:0] sel_val;
	logic        sel_below;
	logic [15:0] offset;
	logic [11:0] speed;

	// Classify both axes against the dead band
	assign h_centered = (frame.horiz >= band_low) && (frame.horiz <= band_high);
	assign v_centered = (frame.vert >= band_low) && (frame.vert <= band_high);
	assign h_below    = frame.horiz < band_low;
	assign v_below    = frame.vert < band_low;

	// Pick the axis that drives: horizontal unless it is centered
	assign sel_val   = h_centered ? frame.vert : frame.horiz;
	assign sel_below = h_centered ? v_below : h_below;

	// Below the band the raw value sets speed, above it the distance past the band
	assign offset = sel_below ? sel_val : 16'(sel_val - band_high);
	assign speed  = div20(offset);

	// Build the command pair
	always_comb begin
		drive = '0;
		if (h_centered) begin
			if (!v_centered) begin
				drive.left_dir    = v_below;
				drive.right_dir   = v_below;
				drive.left_speed  = speed;
				drive.right_speed = speed;
			end
		end else begin
			drive.left_dir    = !h_below;
			drive.right_dir   = h_below;
			drive.left_speed  = speed;
			drive.right_speed = speed;
		end
	end

endmodule

// ===== rtl/joystick_frame_to_motor_drive.sv =====
// Top level of the joystick frame to motor drive block.
// Frame assembly, pipeline and output registers, and the configuration port.
// Depends on jfmd_pkg and jfmd_drive.
//
// Usage:
// Received bytes enter one per item on the s_axis channel (s_axis_tdata[7:0]).
// Four bytes make a frame: horizontal value low then high byte, vertical value
// low then high byte. The fourth byte produces one item on m_axis carrying the
// left and right motor direction and speed; the first three produce nothing.
// The command passes through the frame register and the decision logic into the
// output register before it appears on m_axis. Bytes are taken one per cycle
// while m_axis does not stall.
// When m_axis stalls, the output register holds its item and the frame
// register holds the next frame; a fourth byte is then refused until space
// frees, while the first three bytes of a frame are still taken.
// The dead band (band_low at 0x0, band_high at 0x4) is written over the APB
// port; the user must do so only while idle; the block does not enforce this.
// pready is always high and reads return the register values. Reset clears the
// frame position, assembly registers, all valid flags and sets band 1950..2150.
module joystick_frame_to_motor_drive (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Received bytes
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
	// Motor commands
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata   // [0] left_dir, [12:1] left_speed,
	                                   // [13] right_dir, [25:14] right_speed, [31:26] zero
);
	import jfmd_pkg::*;

	logic [15:0] band_low_q;
	logic [15:0] band_high_q;
	logic [1:0]  pos_q;
	logic [15:0] horiz_q;
	logic [7:0]  vert_lo_q;
	frame_t      frame_s1;
	logic        valid_s1;
	drive_t      drive_c;
	drive_t      out_q;
	logic        out_valid_q;
	logic        in_acc;
	logic        frame_done;
	logic        adv_s1;
	logic        cfg_wr;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_low_q  <= BAND_LOW_RST;
			band_high_q <= BAND_HIGH_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_BAND_LOW:  band_low_q  <= pwdata[15:0];
				REG_BAND_HIGH: band_high_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_BAND_LOW:  prdata = {16'd0, band_low_q};
			REG_BAND_HIGH: prdata = {16'd0, band_high_q};
			default:       prdata = '0;
		endcase
	end

	// Handshake: the frame register advances when the output register frees
	assign adv_s1        = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = (pos_q != POS_V_HI) || !valid_s1 || adv_s1;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign frame_done    = in_acc && (pos_q == POS_V_HI);

	// Assemble the frame one item at a time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= POS_H_LO;
			horiz_q   <= '0;
			vert_lo_q <= '0;
		end else if (in_acc) begin
			pos_q <= pos_q + 2'd1;
			case (pos_q)
				POS_H_LO: horiz_q   <= {8'd0, s_axis_tdata};
				POS_H_HI: horiz_q   <= {s_axis_tdata, horiz_q[7:0]};
				POS_V_LO: vert_lo_q <= s_axis_tdata;
				default: ;
			endcase
		end
	end

	// Frame register: load on the fourth byte, drop once passed on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame_done) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_done) begin
			frame_s1.horiz <= horiz_q;
			frame_s1.vert  <= {s_axis_tdata, vert_lo_q};
		end
	end

	// Decision logic
	jfmd_drive u_drive (
		.frame     (frame_s1),
		.band_low  (band_low_q),
		.band_high (band_high_q),
		.drive     (drive_c)
	);

	// Output register: hold while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_q <= drive_c;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, out_q};

endmodule

// ===== test/joystick_frame_to_motor_drive_tb.sv =====
// Testbench for joystick_frame_to_motor_drive: streams joystick frames, predicts motor commands.
// Checks every command field and the band registers across several dead-band settings.
// Depends on jfmd_pkg and the joystick_frame_to_motor_drive RTL.
`timescale 1ns / 1ps

module joystick_frame_to_motor_drive_tb;

	import jfmd_pkg::*;

	localparam int FRAMES_PER_PHASE = 30;
	localparam int STALL_LIMIT      = 2000;
	localparam int DRAIN_CYCLES     = 4;

	typedef struct packed {
		logic        right_dir;
		logic [11:0] right_speed;
		logic        left_dir;
		logic [11:0] left_speed;
	} motor_cmd_t;

	// Predicts motor commands from received bytes and holds those still due
	class motor_drive_scoreboard;
		logic [15:0] band_lo;
		logic [15:0] band_hi;
		logic [1:0]  frame_pos;
		logic [15:0] horiz_acc;
		logic [7:0]  vert_lo;
		motor_cmd_t  pending_cmds[$];
		int          errors;

		function new();
			band_lo   = 16'd1950;
			band_hi   = 16'd2150;
			frame_pos = POS_H_LO;
			horiz_acc = 16'd0;
			vert_lo   = 8'd0;
			errors    = 0;
		endfunction

		function void set_band(logic idx, logic [31:0] val);
			if (idx == REG_BAND_LOW)
				band_lo = val[15:0];
			else
				band_hi = val[15:0];
		endfunction

		function bit centered(logic [15:0] val);
			return val >= band_lo && val <= band_hi;
		endfunction

		// Speed of an off-center value; below is set when under the band
		function logic [11:0] off_center_speed(logic [15:0] val, output bit below);
			logic [15:0] over;
			over  = val - band_hi;
			below = val < band_lo;
			return below ? 12'(val / 16'd20) : 12'(over / 16'd20);
		endfunction

		function motor_cmd_t decide_drive(logic [15:0] horiz, logic [15:0] vert);
			motor_cmd_t cmd;
			bit         below;
			logic [11:0] speed;
			cmd = '0;
			if (centered(horiz)) begin
				// Same direction on both motors, taken from up-down
				if (!centered(vert)) begin
					speed = off_center_speed(vert, below);
					cmd.left_dir    = below;
					cmd.right_dir   = below;
					cmd.left_speed  = speed;
					cmd.right_speed = speed;
				end
			end else begin
				// Turn in place, direction taken from left-right
				speed = off_center_speed(horiz, below);
				cmd.left_dir    = !below;
				cmd.right_dir   = below;
				cmd.left_speed  = speed;
				cmd.right_speed = speed;
			end
			return cmd;
		endfunction

		function void note_rx_byte(logic [7:0] b);
			case (frame_pos)
				POS_H_LO: horiz_acc = {8'd0, b};
				POS_H_HI: horiz_acc = {b, horiz_acc[7:0]};
				POS_V_LO: vert_lo = b;
				default: pending_cmds.push_back(decide_drive(horiz_acc, {b, vert_lo}));
			endcase
			frame_pos = frame_pos + 2'd1;
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		task check_motor_cmd(logic [31:0] word);
			motor_cmd_t want;
			if (pending_cmds.size() == 0) begin
				report($sformatf("command 0x%08h with none expected", word));
				return;
			end
			want = pending_cmds.pop_front();
			if (word[0] !== want.left_dir)
				report($sformatf("left_dir %b, want %b", word[0], want.left_dir));
			if (word[12:1] !== want.left_speed)
				report($sformatf("left_speed %0d, want %0d", word[12:1], want.left_speed));
			if (word[13] !== want.right_dir)
				report($sformatf("right_dir %b, want %b", word[13], want.right_dir));
			if (word[25:14] !== want.right_speed)
				report($sformatf("right_speed %0d, want %0d", word[25:14], want.right_speed));
			if (word[31:26] !== 6'd0)
				report($sformatf("pad bits 0x%02h not zero", word[31:26]));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;   // [0] left_dir, [12:1] left_speed,
	                             // [13] right_dir, [25:14] right_speed, [31:26] zero

	motor_drive_scoreboard sb;

	int  burst_left;
	bit  pace_on;
	int  quiet_cycles;
	int  rx_cycle;
	int  stall_mode;

	joystick_frame_to_motor_drive u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #1 clk = ~clk;

	// Receiver stall pattern: mode redrawn at random among four modes
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1;
		if (rx_cycle % 64 == 63)
			stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= $urandom_range(0, 2) != 0;
			2: m_axis_tready <= (rx_cycle % 5) != 4;
			default: m_axis_tready <= ((rx_cycle / 8) % 2) == 0;
		endcase
	end

	// Track accepted items; input noted before output so same-edge cases stay ordered
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				sb.note_rx_byte(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_motor_cmd(m_axis_tdata);
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
		    || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Hold off the sender between bursts
	task automatic pace();
		int gap;
		if (pace_on && burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		if (burst_left > 0)
			burst_left--;
	endtask

	task automatic send_byte(logic [7:0] b);
		pace();
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic send_frame(logic [15:0] horiz, logic [15:0] vert);
		send_byte(horiz[7:0]);
		send_byte(horiz[15:8]);
		send_byte(vert[7:0]);
		send_byte(vert[15:8]);
	endtask

	// Drop valid and wait until every command has come out
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending_cmds.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(logic idx, logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.set_band(idx, val);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic apb_check(logic idx);
		logic [31:0] want;
		want = (idx == REG_BAND_LOW) ? {16'd0, sb.band_lo} : {16'd0, sb.band_hi};
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== want)
			sb.report($sformatf("register %0d reads 0x%08h, want 0x%08h", idx, prdata, want));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_band(logic [15:0] lo, logic [15:0] hi);
		logic [15:0] junk_lo;
		logic [15:0] junk_hi;
		// Upper bits carry junk; only the low half may land
		junk_lo = $urandom_range(0, 1) ? 16'($urandom) : 16'd0;
		junk_hi = $urandom_range(0, 1) ? 16'($urandom) : 16'd0;
		apb_write(REG_BAND_LOW, {junk_lo, lo});
		apb_write(REG_BAND_HIGH, {junk_hi, hi});
		apb_check(REG_BAND_LOW);
		apb_check(REG_BAND_HIGH);
	endtask

	// Joystick value biased toward the band edges and the extremes
	function automatic logic [15:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 16'($urandom);
			1: return 16'($urandom_range(sb.band_lo, sb.band_hi));
			2: return sb.band_lo + 16'($urandom_range(0, 2)) - 16'd1;
			3: return sb.band_hi + 16'($urandom_range(0, 2)) - 16'd1;
			4: return 16'($urandom_range(0, 45));
			default: return 16'($urandom_range(65490, 65535));
		endcase
	endfunction

	initial begin
		logic [15:0] lo;
		logic [15:0] hi;
		sb            = new();
		clk           = 1'b0;
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		rx_cycle      = 0;
		stall_mode    = 0;
		quiet_cycles  = 0;
		burst_left    = 0;
		pace_on       = 1'b1;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames on the reset band: stop, each steering case, edges
		apb_check(REG_BAND_LOW);
		apb_check(REG_BAND_HIGH);
		send_frame(16'd1950, 16'd2150);
		send_frame(16'd2150, 16'd1949);
		send_frame(16'd2000, 16'hFFFF);
		send_frame(16'd0, 16'd0);
		send_frame(16'hFFFF, 16'd2000);
		send_frame(16'd1949, 16'd2151);
		drain();

		// Random frames under several bands, including crossed and full-range ones
		for (int phase = 0; phase < 9; phase++) begin
			case (phase)
				0: begin lo = 16'd0;     hi = 16'hFFFF; end
				1: begin lo = 16'hFFFF;  hi = 16'd0;    end
				2: begin lo = 16'd0;     hi = 16'd0;    end
				3: begin lo = 16'hFFFF;  hi = 16'hFFFF; end
				4: begin
					lo = 16'($urandom_range(500, 30000));
					hi = lo - 16'($urandom_range(1, 400));
				end
				8: begin lo = 16'd1950;  hi = 16'd2150; end
				default: begin
					lo = 16'($urandom);
					hi = lo + 16'($urandom_range(0, 65535 - lo));
				end
			endcase
			set_band(lo, hi);
			pace_on    = phase % 2 == 0;
			burst_left = 0;
			for (int f = 0; f < FRAMES_PER_PHASE; f++)
				send_frame(pick_value(), pick_value());
			drain();
		end

		if (sb.errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/jfmd_pkg.sv
rtl/jfmd_drive.sv
rtl/joystick_frame_to_motor_drive.sv
test/joystick_frame_to_motor_drive_tb.sv
